@@ design/carf_pkg.sv @@
// Shared types, constants and helpers for the clipped alpha rectangle fill unit.
// No dependencies; imported by every module of the block.
package carf_pkg;

  localparam int unsigned MAX_SURFACE_DIM = 4096;
  localparam int unsigned DIM_W   = 13;   // surface size register width
  localparam int unsigned COORD_W = 12;   // pixel column / row width
  localparam int unsigned RECT_W  = 16;   // signed rectangle fields
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_COLOR     = 3'd0,
    REG_RECT_LEFT      = 3'd1,
    REG_RECT_TOP       = 3'd2,
    REG_RECT_WIDTH     = 3'd3,
    REG_RECT_HEIGHT    = 3'd4,
    REG_SURFACE_WIDTH  = 3'd5,
    REG_SURFACE_HEIGHT = 3'd6
  } cfg_reg_t;

  // One accepted input beat as held in the input stage.
  typedef struct packed {
    logic [PIX_W-1:0]   dest_pixel;
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
  } pix_beat_t;

  // floor(x / 255), exact for x up to 65279.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

@@ design/carf_axis.sv @@
// One-axis containment test against the fill rectangle clipped to the surface.
// Depends on carf_pkg.
module carf_axis (
  input  logic signed [carf_pkg::RECT_W-1:0] origin,
  input  logic signed [carf_pkg::RECT_W-1:0] length,
  input  logic [carf_pkg::DIM_W-1:0]         extent,
  input  logic [carf_pkg::COORD_W-1:0]       coord,
  output logic                               covered
);
  import carf_pkg::*;

  localparam int unsigned AW = RECT_W + 3;

  logic [DIM_W-1:0]     ext_clamped;
  logic signed [AW-1:0] org_s;
  logic signed [AW-1:0] len_s;
  logic signed [AW-1:0] lo;
  logic signed [AW-1:0] len_c;
  logic signed [AW-1:0] stop;
  logic signed [AW-1:0] ext_s;
  logic signed [AW-1:0] pos_s;

  always_comb begin
    ext_clamped = (extent > DIM_W'(MAX_SURFACE_DIM)) ? DIM_W'(MAX_SURFACE_DIM) : extent;
    org_s = AW'(origin);
    len_s = AW'(length);
    // Negative origin eats into the length and snaps to zero.
    if (org_s < 0) begin
      lo    = '0;
      len_c = len_s + org_s;
    end else begin
      lo    = org_s;
      len_c = len_s;
    end
    stop  = lo + len_c;
    ext_s = signed'({{(AW-DIM_W){1'b0}}, ext_clamped});
    pos_s = signed'({{(AW-COORD_W){1'b0}}, coord});
    // lo <= p < stop already rules out an empty span; p < ext covers the surface clip.
    covered = (pos_s >= lo) && (pos_s < stop) && (pos_s < ext_s);
  end

endmodule

@@ design/carf_blend.sv @@
// Source-over blend of a constant ARGB8888 color into one destination pixel.
// Depends on carf_pkg (div255).
module carf_blend (
  input  logic [carf_pkg::PIX_W-1:0] color,
  input  logic [carf_pkg::PIX_W-1:0] dest,
  output logic [carf_pkg::PIX_W-1:0] blended
);
  import carf_pkg::*;

  logic [7:0]  alpha;
  logic [7:0]  inv;
  logic [7:0]  dst_a;
  logic [15:0] a_prod;
  logic [15:0] ch_sum [3];

  always_comb begin
    alpha  = color[31:24];
    inv    = 8'd255 - alpha;
    dst_a  = dest[31:24];
    a_prod = (8'd255 - dst_a) * alpha;
    blended[31:24] = dst_a + div255(a_prod);
    for (int i = 0; i < 3; i++) begin
      ch_sum[i] = color[i*8 +: 8] * alpha + dest[i*8 +: 8] * inv;
      blended[i*8 +: 8] = div255(ch_sum[i]);
    end
  end

endmodule

@@ design/clipped_alpha_rect_fill_unit.sv @@
// Clipped alpha rectangle fill: blends the fill color into pixels inside the clipped rect.
// Throughput one beat per cycle unless out_stall holds back a full result register.
// Input register, then clip test and blend, then the result register.
// Synchronous active-low reset clears all config registers to 0 and empties both stages.
// Depends on carf_pkg, carf_axis, carf_blend.
module clipped_alpha_rect_fill_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [carf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [carf_pkg::PIX_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [carf_pkg::PIX_W-1:0]         in_dest_pixel,
  input  logic [carf_pkg::COORD_W-1:0]       in_pixel_column,
  input  logic [carf_pkg::COORD_W-1:0]       in_pixel_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [carf_pkg::PIX_W-1:0]         out_pixel_out,
  output logic                               out_was_changed
);
  import carf_pkg::*;

  logic [PIX_W-1:0]         fill_color_r;
  logic signed [RECT_W-1:0] rect_left_r;
  logic signed [RECT_W-1:0] rect_top_r;
  logic signed [RECT_W-1:0] rect_width_r;
  logic signed [RECT_W-1:0] rect_height_r;
  logic [DIM_W-1:0]         surface_width_r;
  logic [DIM_W-1:0]         surface_height_r;

  logic        s1_valid_r, s1_valid_nxt;
  pix_beat_t   s1_r;
  logic        out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pixel_r;
  logic        out_changed_r;

  logic        in_take;
  logic        s2_load;
  logic        inside_x, inside_y;
  logic        hit;
  logic [PIX_W-1:0] blended;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_color_r     <= '0;
      rect_left_r      <= '0;
      rect_top_r       <= '0;
      rect_width_r     <= '0;
      rect_height_r    <= '0;
      surface_width_r  <= '0;
      surface_height_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FILL_COLOR:     fill_color_r     <= cfg_data;
        REG_RECT_LEFT:      rect_left_r      <= cfg_data[RECT_W-1:0];
        REG_RECT_TOP:       rect_top_r       <= cfg_data[RECT_W-1:0];
        REG_RECT_WIDTH:     rect_width_r     <= cfg_data[RECT_W-1:0];
        REG_RECT_HEIGHT:    rect_height_r    <= cfg_data[RECT_W-1:0];
        REG_SURFACE_WIDTH:  surface_width_r  <= cfg_data[DIM_W-1:0];
        REG_SURFACE_HEIGHT: surface_height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Result register takes a new beat when empty or being drained.
  assign s2_load  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !s2_load);
    out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.dest_pixel   <= in_dest_pixel;
      s1_r.pixel_column <= in_pixel_column;
      s1_r.pixel_row    <= in_pixel_row;
    end
    if (s2_load && s1_valid_r) begin
      out_pixel_r   <= hit ? blended : s1_r.dest_pixel;
      out_changed_r <= hit;
    end
  end

  carf_axis u_axis_x (
    .origin  (rect_left_r),
    .length  (rect_width_r),
    .extent  (surface_width_r),
    .coord   (s1_r.pixel_column),
    .covered (inside_x)
  );

  carf_axis u_axis_y (
    .origin  (rect_top_r),
    .length  (rect_height_r),
    .extent  (surface_height_r),
    .coord   (s1_r.pixel_row),
    .covered (inside_y)
  );

  carf_blend u_blend (
    .color   (fill_color_r),
    .dest    (s1_r.dest_pixel),
    .blended (blended)
  );

  assign hit = (fill_color_r[31:24] != 8'd0) && inside_x && inside_y;

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pixel_r;
  assign out_was_changed = out_changed_r;

  // A held input beat moves to the result register once it has room.
  a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_load |=> out_valid_r)
    else $error("input stage beat not moved to result register");

  // Input stage holds its beat while the result side is blocked.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r && $stable(s1_r))
    else $error("input stage beat lost while stalled");

  // Backpressure only when both stages are occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("stall raised with a free stage");

endmodule
